/* rtl/pressure_sensor_compensation_macros.svh */
// Assertion helpers for the checker in psc_checker.sv.
`ifndef PRESSURE_SENSOR_COMPENSATION_MACROS_SVH
`define PRESSURE_SENSOR_COMPENSATION_MACROS_SVH

// Clocked check, quiet while reset is held.
`define PSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs through reset.
`define PSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/psc_pkg.sv */
`default_nettype none
package psc_pkg;

  localparam int IN_W   = 72;
  localparam int OUT_W  = 40;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 17;

  localparam logic [CFG_AW-1:0] REG_COEFF_ZERO  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_COEFF_ONE   = 3'd1;
  localparam logic [CFG_AW-1:0] REG_COEFF_TWO   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_COEFF_THREE = 3'd3;
  localparam logic [CFG_AW-1:0] REG_PREF_LOW    = 3'd4;
  localparam logic [CFG_AW-1:0] REG_PREF_MID    = 3'd5;
  localparam logic [CFG_AW-1:0] REG_PREF_HIGH   = 3'd6;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  localparam int LUT_LOWER = 3670016;
  localparam int LUT_UPPER = 12058624;
  // table anchors in units of 2^-4
  localparam logic signed [31:0] LUT_LOWER_Q4 = 32'(LUT_LOWER * 16);
  localparam logic signed [31:0] LUT_UPPER_Q4 = 32'(LUT_UPPER * 16);

  localparam logic [14:0] TEMP_SPAN   = 15'd17500;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;
  localparam logic signed [14:0] TEMP_MIN = -15'sd4500;
  localparam logic signed [14:0] TEMP_MAX = 15'sd13000;
  localparam logic [22:0] PRESS_MAX   = 23'h7FFFFF;

  // Divider geometry: remainder width and quotient bits
  localparam int DIV_W = 102;
  localparam int Q_W   = 24;

  function automatic logic [7:0] crc8_byte(input logic [7:0] c_in, input logic [7:0] d);
    logic [7:0] c;
    c = c_in ^ d;
    for (int b = 0; b < 8; b++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* rtl/pressure_sensor_compensation.sv */
`default_nettype none
// Pressure sensor compensation.
// Input channel in_*: one raw frame per beat, accepted when in_tvalid and
// in_tready are both high. Output channel out_*: one result per frame, in
// order; out_tuser is frame_ok, low when a CRC fails or the curve through
// the three table points is degenerate (then out_tdata is all zeros).
// Configuration: write cfg_wdata into register cfg_addr while cfg_we is high;
// only while no frame is in flight. Indexes beyond the list are dropped.
// Throughput: one frame per cycle while the skid is empty. Latency: 35 register
// stages from the edge that accepts the input beat to out_tvalid:
// ten arithmetic stages (CRC, table points, curve products, partial-product
// sums, sign fix, divider set-up), a 24-stage restoring divider that retires
// one quotient bit per stage, and the output register.
// The whole pipeline advances together; a two-entry output (register plus
// skid) lets the input keep accepting while a result waits. When the
// receiver stalls, the next result parks in the skid and in_tready stays low
// until the skid drains; nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the pipeline and output, sets the
// coefficients to zero and the reference pressures to 45000, 80000, 105000.
module pressure_sensor_compensation (
  input  wire                          clk,
  input  wire                          rst_n,
  // temp_word, temp_check, press_upper_word, press_upper_check,
  // press_lower_word, press_lower_check
  input  wire  [psc_pkg::IN_W-1:0]     in_tdata,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  // pressure_out[22:0], temp_centi[37:23], zero pad[39:38]
  output logic [psc_pkg::OUT_W-1:0]    out_tdata,
  // frame_ok
  output logic                         out_tuser,
  output logic                         out_tvalid,
  input  wire                          out_tready,
  input  wire                          cfg_we,
  input  wire  [psc_pkg::CFG_AW-1:0]   cfg_addr,
  input  wire  [psc_pkg::CFG_DW-1:0]   cfg_wdata
);
  import psc_pkg::*;

  // ---------------- configuration registers ----------------
  logic signed [15:0] coef_r [4];
  logic [16:0] pref_r [3];
  logic signed [17:0] d1_r, d0_r;   // p1-p2, p1-p0
  logic signed [34:0] e1_r, e0_r;   // p0*(p1-p2), p2*(p1-p0)
  logic signed [17:0] d1_nxt, d0_nxt;
  logic signed [35:0] e1_full, e0_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) coef_r[i] <= '0;
      pref_r[0] <= 17'd45000;
      pref_r[1] <= 17'd80000;
      pref_r[2] <= 17'd105000;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_COEFF_ZERO:  coef_r[0] <= cfg_wdata[15:0];
        REG_COEFF_ONE:   coef_r[1] <= cfg_wdata[15:0];
        REG_COEFF_TWO:   coef_r[2] <= cfg_wdata[15:0];
        REG_COEFF_THREE: coef_r[3] <= cfg_wdata[15:0];
        REG_PREF_LOW:    pref_r[0] <= cfg_wdata;
        REG_PREF_MID:    pref_r[1] <= cfg_wdata;
        REG_PREF_HIGH:   pref_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Derived weights follow the registers every cycle; a frame reaches
  // them several stages after entry, well after any write settles.
  always_comb begin
    d1_nxt  = $signed({1'b0, pref_r[1]}) - $signed({1'b0, pref_r[2]});
    d0_nxt  = $signed({1'b0, pref_r[1]}) - $signed({1'b0, pref_r[0]});
    e1_full = $signed({1'b0, pref_r[0]}) * d1_nxt;
    e0_full = $signed({1'b0, pref_r[2]}) * d0_nxt;
  end

  always_ff @(posedge clk) begin
    d1_r <= d1_nxt;
    d0_r <= d0_nxt;
    e1_r <= e1_full[34:0];
    e0_r <= e0_full[34:0];
  end

  // ---------------- pipeline control ----------------
  logic en;
  logic sk_valid_r;
  assign en        = !sk_valid_r;
  assign in_tready = en;

  logic a_v_r, b_v_r, c_v_r, d_v_r, e_v_r, f_v_r, g_v_r, h_v_r, i_v_r;
  logic [Q_W:0] dv_v_r;

  // ---------------- stage A: first CRC byte, squares, temperature ------
  logic [15:0] tw, pu, pl;
  logic signed [15:0] t_in;
  logic signed [31:0] tt_full;
  logic [30:0] tc_prod;
  logic [31:0] tc_sum;

  logic [7:0] a_crc_r [3];
  logic [7:0] a_lo_r [3];
  logic [7:0] a_chk_r [3];
  logic [30:0] a_tt_r;
  logic [23:0] a_cnt_r;
  logic [14:0] a_tc_r;

  always_comb begin
    tw      = in_tdata[15:0];
    pu      = in_tdata[39:24];
    pl      = in_tdata[63:48];
    t_in    = $signed({~tw[15], tw[14:0]});   // T - 32768
    tt_full = t_in * t_in;
    tc_prod = TEMP_SPAN * tw;
    tc_sum  = {1'b0, tc_prod} + 32'd32768;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_crc_r[0] <= crc8_byte(CRC_INIT, tw[15:8]);
      a_crc_r[1] <= crc8_byte(CRC_INIT, pu[15:8]);
      a_crc_r[2] <= crc8_byte(CRC_INIT, pl[15:8]);
      a_lo_r[0]  <= tw[7:0];
      a_lo_r[1]  <= pu[7:0];
      a_lo_r[2]  <= pl[7:0];
      a_chk_r[0] <= in_tdata[23:16];
      a_chk_r[1] <= in_tdata[47:40];
      a_chk_r[2] <= in_tdata[71:64];
      a_tt_r     <= tt_full[30:0];
      a_cnt_r    <= {pu, pl[15:8]};
      a_tc_r     <= tc_sum[30:16] - TEMP_OFFSET;
    end
  end

  // ---------------- stage B: CRC verdict, coefficient products ---------
  logic signed [47:0] ct_full [3];
  logic b_ok_r;
  logic signed [46:0] b_ct_r [3];
  logic [23:0] b_cnt_r;
  logic [14:0] b_tc_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ct_full[i] = coef_r[i] * $signed({1'b0, a_tt_r});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_ok_r <= (crc8_byte(a_crc_r[0], a_lo_r[0]) == a_chk_r[0]) &&
                (crc8_byte(a_crc_r[1], a_lo_r[1]) == a_chk_r[1]) &&
                (crc8_byte(a_crc_r[2], a_lo_r[2]) == a_chk_r[2]);
      for (int i = 0; i < 3; i++) b_ct_r[i] <= ct_full[i][46:0];
      b_cnt_r <= a_cnt_r;
      b_tc_r  <= a_tc_r;
    end
  end

  // ---------------- stage C: table points in 2^-4 units ----------------
  logic signed [26:0] sh [3];
  logic c_ok_r;
  logic signed [31:0] c_l0_r, c_l1_r, c_l2_r;
  logic [23:0] c_cnt_r;
  logic [14:0] c_tc_r;

  always_comb begin
    // floor division by 2^20
    for (int i = 0; i < 3; i++) sh[i] = $signed(b_ct_r[i][46:20]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_ok_r  <= b_ok_r;
      c_l0_r  <= LUT_LOWER_Q4 + $signed({{5{sh[0][26]}}, sh[0]});
      c_l1_r  <= $signed({coef_r[3][15], coef_r[3], 15'b0}) +
                 $signed({{5{sh[1][26]}}, sh[1]});
      c_l2_r  <= LUT_UPPER_Q4 + $signed({{5{sh[2][26]}}, sh[2]});
      c_cnt_r <= b_cnt_r;
      c_tc_r  <= b_tc_r;
    end
  end

  // ---------------- stage D: differences ----------------
  logic signed [32:0] xs, dx0_w, dx2_w, d12_w, d10_w;
  logic d_ok_r;
  logic signed [29:0] d_dx0_r, d_dx2_r;
  logic signed [31:0] d_d12_r, d_d10_r;
  logic [14:0] d_tc_r;

  always_comb begin
    xs    = $signed({5'b0, c_cnt_r, 4'b0});
    dx0_w = xs - $signed({c_l0_r[31], c_l0_r});
    dx2_w = xs - $signed({c_l2_r[31], c_l2_r});
    d12_w = $signed({c_l1_r[31], c_l1_r}) - $signed({c_l2_r[31], c_l2_r});
    d10_w = $signed({c_l1_r[31], c_l1_r}) - $signed({c_l0_r[31], c_l0_r});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_ok_r  <= c_ok_r;
      d_dx0_r <= dx0_w[29:0];
      d_dx2_r <= dx2_w[29:0];
      d_d12_r <= d12_w[31:0];
      d_d10_r <= d10_w[31:0];
      d_tc_r  <= c_tc_r;
    end
  end

  // ---------------- stage E: K and M ----------------
  logic signed [61:0] k_full, m_full;
  logic e_ok_r;
  logic signed [61:0] e_k_r, e_m_r;
  logic [14:0] e_tc_r;

  always_comb begin
    k_full = d_dx0_r * d_d12_r;
    m_full = d_dx2_r * d_d10_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_ok_r <= d_ok_r;
      e_k_r  <= k_full;
      e_m_r  <= m_full;
      e_tc_r <= d_tc_r;
    end
  end

  // ---------------- stage F: partial products, 32-bit halves -----------
  logic signed [32:0] m_lo, k_lo;
  logic signed [29:0] m_hi, k_hi;
  logic f_ok_r;
  logic signed [67:0] f_me_lo_r, f_ke_lo_r;
  logic signed [64:0] f_me_hi_r, f_ke_hi_r;
  logic signed [50:0] f_md_lo_r, f_kd_lo_r;
  logic signed [47:0] f_md_hi_r, f_kd_hi_r;
  logic [14:0] f_tc_r;

  always_comb begin
    m_lo = $signed({1'b0, e_m_r[31:0]});
    k_lo = $signed({1'b0, e_k_r[31:0]});
    m_hi = e_m_r[61:32];
    k_hi = e_k_r[61:32];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_ok_r    <= e_ok_r;
      f_me_lo_r <= m_lo * e1_r;
      f_me_hi_r <= m_hi * e1_r;
      f_ke_lo_r <= k_lo * e0_r;
      f_ke_hi_r <= k_hi * e0_r;
      f_md_lo_r <= m_lo * d1_r;
      f_md_hi_r <= m_hi * d1_r;
      f_kd_lo_r <= k_lo * d0_r;
      f_kd_hi_r <= k_hi * d0_r;
      f_tc_r    <= e_tc_r;
    end
  end

  // ---------------- stage G: recombine halves ----------------
  logic signed [96:0] me_w, ke_w;
  logic signed [79:0] md_w, kd_w;
  logic g_ok_r;
  logic signed [95:0] g_me_r, g_ke_r;
  logic signed [78:0] g_md_r, g_kd_r;
  logic [14:0] g_tc_r;

  always_comb begin
    me_w = $signed({f_me_hi_r, 32'b0}) + $signed({{29{f_me_lo_r[67]}}, f_me_lo_r});
    ke_w = $signed({f_ke_hi_r, 32'b0}) + $signed({{29{f_ke_lo_r[67]}}, f_ke_lo_r});
    md_w = $signed({f_md_hi_r, 32'b0}) + $signed({{29{f_md_lo_r[50]}}, f_md_lo_r});
    kd_w = $signed({f_kd_hi_r, 32'b0}) + $signed({{29{f_kd_lo_r[50]}}, f_kd_lo_r});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_ok_r <= f_ok_r;
      g_me_r <= me_w[95:0];
      g_ke_r <= ke_w[95:0];
      g_md_r <= md_w[78:0];
      g_kd_r <= kd_w[78:0];
      g_tc_r <= f_tc_r;
    end
  end

  // ---------------- stage H: numerator and denominator ----------------
  logic signed [95:0] num_w;
  logic signed [78:0] den_w;
  logic h_ok_r;
  logic signed [95:0] h_num_r;
  logic signed [77:0] h_den_r;
  logic [14:0] h_tc_r;

  always_comb begin
    num_w = g_me_r - g_ke_r;
    den_w = g_md_r - g_kd_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_ok_r  <= g_ok_r;
      h_num_r <= num_w;
      h_den_r <= den_w[77:0];
      h_tc_r  <= g_tc_r;
    end
  end

  // ---------------- stage I: make the denominator positive -------------
  logic signed [95:0] num_fix;
  logic signed [77:0] den_fix;
  logic i_ok_r, i_neg_r;
  logic [94:0] i_num_r;
  logic [76:0] i_den_r;
  logic [14:0] i_tc_r;

  always_comb begin
    num_fix = h_den_r[77] ? -h_num_r : h_num_r;
    den_fix = h_den_r[77] ? -h_den_r : h_den_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      i_ok_r  <= h_ok_r && (h_den_r != '0);
      i_neg_r <= num_fix[95];
      i_num_r <= num_fix[94:0];
      i_den_r <= den_fix[76:0];
      i_tc_r  <= h_tc_r;
    end
  end

  // ---------------- stage J: round-half-up operands -------------------
  // q = (128*num + den) / (2*den)
  logic [DIV_W-1:0] dv_rem_r [Q_W+1];
  logic [77:0]      dv_den_r [Q_W+1];
  logic [Q_W-1:0]   dv_q_r   [Q_W+1];
  logic             dv_ok_r  [Q_W+1];
  logic             dv_neg_r [Q_W+1];
  logic [14:0]      dv_tc_r  [Q_W+1];

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem_r[0] <= DIV_W'({i_num_r, 7'b0}) + DIV_W'(i_den_r);
      dv_den_r[0] <= {i_den_r, 1'b0};
      dv_q_r[0]   <= '0;
      dv_ok_r[0]  <= i_ok_r;
      dv_neg_r[0] <= i_neg_r;
      dv_tc_r[0]  <= i_tc_r;
    end
  end

  // ---------------- divider: one quotient bit per stage ----------------
  for (genvar k = 0; k < Q_W; k++) begin : g_div
    localparam int SH = Q_W - 1 - k;
    logic [DIV_W-1:0] trial;
    logic take;
    assign trial = DIV_W'(dv_den_r[k]) << SH;
    assign take  = dv_rem_r[k] >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem_r[k+1] <= take ? dv_rem_r[k] - trial : dv_rem_r[k];
        dv_q_r[k+1]   <= take ? dv_q_r[k] | (Q_W'(1) << SH) : dv_q_r[k];
        dv_den_r[k+1] <= dv_den_r[k];
        dv_ok_r[k+1]  <= dv_ok_r[k];
        dv_neg_r[k+1] <= dv_neg_r[k];
        dv_tc_r[k+1]  <= dv_tc_r[k];
      end
    end
  end

  // ---------------- valid bits ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r  <= 1'b0;
      b_v_r  <= 1'b0;
      c_v_r  <= 1'b0;
      d_v_r  <= 1'b0;
      e_v_r  <= 1'b0;
      f_v_r  <= 1'b0;
      g_v_r  <= 1'b0;
      h_v_r  <= 1'b0;
      i_v_r  <= 1'b0;
      dv_v_r <= '0;
    end else if (en) begin
      a_v_r  <= in_tvalid;
      b_v_r  <= a_v_r;
      c_v_r  <= b_v_r;
      d_v_r  <= c_v_r;
      e_v_r  <= d_v_r;
      f_v_r  <= e_v_r;
      g_v_r  <= f_v_r;
      h_v_r  <= g_v_r;
      i_v_r  <= h_v_r;
      dv_v_r <= {dv_v_r[Q_W-1:0], i_v_r};
    end
  end

  // ---------------- result formatting ----------------
  logic [22:0] pres;
  logic [14:0] tc_out;
  logic        ok_out;
  logic [OUT_W-1:0] res_data;

  always_comb begin
    ok_out = dv_ok_r[Q_W];
    priority if (!ok_out || dv_neg_r[Q_W]) begin
      pres = '0;
    end else if (dv_q_r[Q_W][Q_W-1]) begin
      pres = PRESS_MAX;           // saturate above range
    end else begin
      pres = dv_q_r[Q_W][22:0];
    end
    tc_out   = ok_out ? dv_tc_r[Q_W] : '0;
    res_data = {2'b0, tc_out, pres};
  end

  // ---------------- output register and skid ----------------
  logic out_valid_r, out_user_r, sk_user_r;
  logic [OUT_W-1:0] out_data_r, sk_data_r;
  logic out_take;

  assign out_take   = out_valid_r && out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sk_valid_r  <= 1'b0;
    end else if (sk_valid_r) begin
      // pipeline held; drain the skid first
      if (out_take) begin
        out_valid_r <= 1'b1;
        sk_valid_r  <= 1'b0;
      end
    end else if (dv_v_r[Q_W]) begin
      if (!out_valid_r || out_take) begin
        out_valid_r <= 1'b1;
      end else begin
        sk_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sk_valid_r) begin
      if (out_take) begin
        out_data_r <= sk_data_r;
        out_user_r <= sk_user_r;
      end
    end else if (dv_v_r[Q_W]) begin
      if (!out_valid_r || out_take) begin
        out_data_r <= res_data;
        out_user_r <= ok_out;
      end else begin
        sk_data_r <= res_data;
        sk_user_r <= ok_out;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/psc_checker.sv */
`default_nettype none
`include "pressure_sensor_compensation_macros.svh"
module psc_checker (
  input wire                        clk,
  input wire                        rst_n,
  input wire                        in_tready,
  input wire [psc_pkg::OUT_W-1:0]   out_tdata,
  input wire                        out_tuser,
  input wire                        out_tvalid,
  input wire                        out_tready
);
  import psc_pkg::*;

  logic               out_stall;
  logic signed [14:0] temp_seen;
  logic               temp_fits;
  logic               shape_ok;

  assign out_stall = out_tvalid && !out_tready;
  assign temp_seen = out_tdata[37:23];
  assign temp_fits = (temp_seen >= TEMP_MIN) && (temp_seen <= TEMP_MAX);
  // failed frame carries zeros, good frame a plausible temperature
  assign shape_ok  = out_tuser ? temp_fits : (out_tdata == '0);

  // reset empties output and skid
  `PSC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (!out_tvalid && in_tready), "busy after reset")

  // a stalled result holds
  `PSC_ASSERT(a_out_hold, out_stall |=> out_tvalid, "stalled result dropped")
  `PSC_ASSERT(a_data_hold, out_stall |=> $stable({out_tuser, out_tdata}), "stalled beat changed")

  // input backpressure only follows an output stall
  `PSC_ASSERT(a_ready_drop, $fell(in_tready) |-> $past(out_stall), "ready fell without a stall")

  `PSC_ASSERT(a_result_shape, out_tvalid |-> shape_ok, "result fields out of shape")

endmodule

bind pressure_sensor_compensation psc_checker u_psc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
`default_nettype wire

/* bench/pressure_sensor_compensation_test.sv */
`default_nettype none
module pressure_sensor_compensation_test;
  import psc_pkg::*;

  // Index past the register list; the block must drop writes to it.
  localparam logic [CFG_AW-1:0] REG_SPARE = 3'd7;

  typedef logic signed [255:0] wide_t;

  typedef struct packed {
    logic        frame_ok;
    logic [22:0] pressure;
    logic [14:0] temp_centi;
  } reading_t;

  // Compensation predictor plus the queue of readings still owed by the block.
  class reading_board;
    longint   coeff [4];
    longint   pref [3];
    reading_t owed [$];
    int       mismatches;
    int       checked;
    int       good_frames;

    function new();
      coeff = '{0, 0, 0, 0};
      pref  = '{45000, 80000, 105000};
    endfunction

    function void set_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
      if (idx < 4) coeff[idx] = longint'($signed(val[15:0]));
      else if (idx < 7) pref[idx - 4] = longint'(val);
    endfunction

    function logic [7:0] word_crc(logic [15:0] w);
      logic [7:0] c;
      c = 8'hFF;
      for (int i = 0; i < 2; i++) begin
        c = c ^ (i == 0 ? w[15:8] : w[7:0]);
        for (int b = 0; b < 8; b++) c = c[7] ? ((c << 1) ^ 8'h31) : (c << 1);
      end
      return c;
    endfunction

    // Note an accepted frame: work out the reading it must produce.
    function void note_frame(logic [IN_W-1:0] d);
      logic [15:0] tw, pu, pl;
      longint t, tt, l0, l1, l2, x;
      wide_t k, m, num, den, q, p0, p1, p2;
      reading_t r;
      tw = d[15:0]; pu = d[39:24]; pl = d[63:48];
      r = '0;
      if (word_crc(tw) == d[23:16] && word_crc(pu) == d[47:40] && word_crc(pl) == d[71:64])
      begin
        t  = longint'(tw) - 32768;
        tt = t * t;
        l0 = (longint'(LUT_LOWER) * 64'sd16777216 + coeff[0] * tt) >>> 20;
        l1 = (64'sd2048 * coeff[3] * 64'sd16777216 + coeff[1] * tt) >>> 20;
        l2 = (longint'(LUT_UPPER) * 64'sd16777216 + coeff[2] * tt) >>> 20;
        x  = longint'({pu, pl[15:8]}) * 16;
        p0 = wide_t'(pref[0]); p1 = wide_t'(pref[1]); p2 = wide_t'(pref[2]);
        k   = wide_t'(x - l0) * wide_t'(l1 - l2);
        m   = wide_t'(x - l2) * wide_t'(l1 - l0);
        num = m * (p0 * (p1 - p2)) - k * (p2 * (p1 - p0));
        den = m * (p1 - p2) - k * (p1 - p0);
        if (den != 0) begin
          if (den < 0) begin
            den = -den;
            num = -num;
          end
          r.frame_ok = 1'b1;
          if (num < 0) r.pressure = '0;
          else begin
            q = (num * 128 + den) / (den * 2);
            r.pressure = (q > 8388607) ? PRESS_MAX : q[22:0];
          end
          r.temp_centi = 15'(int'((32'd17500 * tw + 32'd32768) >> 16) - 4500);
          good_frames++;
        end
      end
      owed.push_back(r);
    endfunction

    // Check one reading beat against the oldest one owed.
    function void check_reading(logic ok, logic [OUT_W-1:0] d);
      reading_t got, want;
      got = '{ok, d[22:0], d[37:23]};
      checked++;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected reading %h", got);
        return;
      end
      want = owed.pop_front();
      if (got !== want || d[39:38] !== 2'b00) begin
        mismatches++;
        if (mismatches <= 10)
          $display("reading %0d: expected ok=%b p=%h t=%h, got ok=%b p=%h t=%h pad=%b",
                   checked, want.frame_ok, want.pressure, want.temp_centi,
                   got.frame_ok, got.pressure, got.temp_centi, d[39:38]);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic [IN_W-1:0]   in_tdata = '0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [OUT_W-1:0]  out_tdata;
  logic              out_tuser;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  reading_board board = new();
  bit  calm;          // no idling on either side
  int  hold_request;  // long receiver hold-off, in cycles
  int  frames_sent;

  pressure_sensor_compensation uut (
    .clk, .rst_n, .in_tdata, .in_tvalid, .in_tready, .out_tdata, .out_tuser,
    .out_tvalid, .out_tready, .cfg_we, .cfg_addr, .cfg_wdata
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Sample every reading beat at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_reading(out_tuser, out_tdata);
  end

  // Receiver: random stall bursts, one long hold-off on request, none when calm.
  always @(negedge clk) begin : receiver
    int stall_left;
    if (hold_request > 0) begin
      stall_left = hold_request;
      hold_request = 0;
    end
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if (!calm && $urandom_range(0, 9) < 3) begin
      out_tready <= 1'b0;
      stall_left = $urandom_range(0, 13);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Build a frame; bad_mask bit i spoils the CRC byte of word i.
  function automatic logic [IN_W-1:0] frame(logic [15:0] tw, logic [15:0] pu,
                                            logic [15:0] pl, logic [2:0] bad_mask);
    logic [7:0] ct, cu, cl;
    ct = board.word_crc(tw) ^ (bad_mask[0] ? 8'($urandom_range(1, 255)) : 8'h00);
    cu = board.word_crc(pu) ^ (bad_mask[1] ? 8'($urandom_range(1, 255)) : 8'h00);
    cl = board.word_crc(pl) ^ (bad_mask[2] ? 8'($urandom_range(1, 255)) : 8'h00);
    return {cl, pl, cu, pu, ct, tw};
  endfunction

  // Offer one frame, hold it until accepted, then maybe idle a burst.
  task automatic send_frame(logic [IN_W-1:0] d);
    @(negedge clk);
    in_tdata  <= d;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    board.note_frame(d);
    frames_sent++;
    if (!calm && $urandom_range(0, 9) < 2) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(0, 13)) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (board.owed.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    board.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_setting(logic [15:0] c0, logic [15:0] c1, logic [15:0] c2,
                              logic [15:0] c3, logic [16:0] lo, logic [16:0] mid,
                              logic [16:0] hi);
    write_reg(REG_COEFF_ZERO, CFG_DW'(c0));
    write_reg(REG_COEFF_ONE, CFG_DW'(c1));
    write_reg(REG_COEFF_TWO, CFG_DW'(c2));
    write_reg(REG_COEFF_THREE, CFG_DW'(c3));
    write_reg(REG_PREF_LOW, lo);
    write_reg(REG_PREF_MID, mid);
    write_reg(REG_PREF_HIGH, hi);
    write_reg(REG_SPARE, CFG_DW'($urandom()));
  endtask

  // Mostly well-formed frames with random content; some spoiled, some raw noise.
  task automatic random_frames(int count);
    logic [15:0] tw, pu, pl;
    for (int i = 0; i < count; i++) begin
      tw = 16'($urandom_range(0, 65535));
      pu = 16'($urandom_range(0, 65535));
      pl = 16'($urandom_range(0, 65535));
      case ($urandom_range(0, 19))
        0:       send_frame({8'($urandom()), pl, 8'($urandom()), pu, 8'($urandom()), tw});
        1, 2:    send_frame(frame(tw, pu, pl, 3'($urandom_range(1, 7))));
        3:       send_frame(frame(16'($urandom_range(0, 1) * 65535), pu, pl, 3'b000));
        default: send_frame(frame(tw, pu, pl, 3'b000));
      endcase
    end
  endtask

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // Directed frames on the reset setting: field extremes and each bad CRC.
    send_frame(frame(16'h0000, 16'h0000, 16'h0000, 3'b000));
    send_frame(frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 3'b000));
    send_frame(frame(16'h8000, 16'h8000, 16'h8000, 3'b000));
    send_frame(frame(16'h0000, 16'hFFFF, 16'h00FF, 3'b000));
    send_frame(frame(16'hFFFF, 16'h0038, 16'h0000, 3'b000));
    send_frame(frame(16'h6666, 16'h00B8, 16'h0000, 3'b000));
    send_frame(frame(16'h6666, 16'h1234, 16'h5600, 3'b001));
    send_frame(frame(16'h6666, 16'h1234, 16'h5600, 3'b010));
    send_frame(frame(16'h6666, 16'h1234, 16'h5600, 3'b100));
    send_frame(frame(16'h6666, 16'h1234, 16'h5600, 3'b111));
    send_frame({IN_W{1'b1}});
    send_frame('0);
    drain();

    // Most negative coefficients, widest reference spread.
    load_setting(16'h8000, 16'h8000, 16'h8000, 16'h8000, 17'd0, 17'd65536, 17'h1FFFF);
    send_frame(frame(16'h0000, 16'h0000, 16'h0000, 3'b000));
    send_frame(frame(16'hFFFF, 16'hFFFF, 16'hFF00, 3'b000));
    // Block the receiver for a long stretch while frames keep coming.
    hold_request = 300;
    random_frames(300);
    drain();

    // Most positive coefficients, low and mid references at the top, high reference at 1.
    load_setting(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 17'h1FFFF, 17'h1FFFF, 17'd1);
    random_frames(250);
    drain();

    // Equal references: the curve is degenerate for every frame.
    load_setting(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
                 17'd70000, 17'd70000, 17'd70000);
    random_frames(60);
    drain();

    // Small random coefficients zero to two, any fourth coefficient, the usual references.
    load_setting(16'($urandom_range(0, 400) - 200), 16'($urandom_range(0, 400) - 200),
                 16'($urandom_range(0, 400) - 200), 16'($urandom_range(0, 65535)),
                 17'd45000, 17'd80000, 17'd105000);
    random_frames(400);
    drain();

    // Fully random setting, then a calm stretch with no idling.
    load_setting(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
                 17'($urandom()), 17'($urandom()), 17'($urandom()));
    random_frames(250);
    calm = 1'b1;
    random_frames(200);
    drain();

    $display("%0d frames over six register settings, %0d readings checked, %0d valid",
             frames_sent, board.checked, board.good_frames);
    $display("covered bad CRCs, degenerate curves, saturation and a long output stall");
    if (board.mismatches == 0 && board.owed.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d readings missing", board.mismatches, board.owed.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* pressure_sensor_compensation.f */
+incdir+rtl
rtl/psc_pkg.sv
rtl/pressure_sensor_compensation.sv
rtl/psc_checker.sv
bench/pressure_sensor_compensation_test.sv
